### rtl/assert_macros.svh
// Assertion macros shared by the framer checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define DSIEF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dsief assertion failed");

// Clocked assertion that also holds across reset.
`define DSIEF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("dsief assertion failed");

`endif

### rtl/dsief_pkg.sv
// Types, codes and the data type decoder for the DSI escape packet framer.
// No dependencies.
package dsief_pkg;

   localparam logic [2:0] CMD_HEADER     = 3'd0;
   localparam logic [2:0] CMD_PAYLOAD    = 3'd1;
   localparam logic [2:0] CMD_OPEN       = 3'd2;
   localparam logic [2:0] CMD_CLOSE      = 3'd3;
   localparam logic [2:0] CMD_VIDEO_ON   = 3'd4;
   localparam logic [2:0] CMD_VIDEO_OFF  = 3'd5;

   localparam logic [1:0] ST_NOT_READY   = 2'd0;
   localparam logic [1:0] ST_READY       = 2'd1;
   localparam logic [1:0] ST_SENDING     = 2'd2;
   localparam logic [1:0] ST_VIDEO       = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_STATE   = 2'd1;
   localparam logic [1:0] STATUS_TYPE    = 2'd2;

   localparam logic [1:0] LANE_LAST      = 2'd3;

   typedef enum logic [1:0] {
      KIND_INVALID,
      KIND_SHORT,
      KIND_LONG
   } kind_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  data_id;
      logic [7:0]  param0;
      logic [7:0]  param1;
      logic [15:0] word_count;
      logic        hs_mode;
      logic [7:0]  payload_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        word_valid;
      logic [31:0] tx_word;
      logic        long_frame;
      logic        packet_done;
      logic [1:0]  api_state_out;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  api_state;
      logic [15:0] bytes_left;
      logic [1:0]  byte_lane;
      logic [23:0] pack_buffer;
   } state_type;

   function automatic kind_type classify(input logic [7:0] id);
      kind_type kind;
      case (id)
         8'h01, 8'h11, 8'h21, 8'h31, 8'h08,
         8'h02, 8'h12, 8'h22, 8'h32,
         8'h03, 8'h13, 8'h23,
         8'h04, 8'h14, 8'h24,
         8'h05, 8'h15, 8'h06, 8'h37: kind = KIND_SHORT;
         8'h39, 8'h09, 8'h19, 8'h29,
         8'h0E, 8'h1E, 8'h2E, 8'h3E: kind = KIND_LONG;
         default:                    kind = KIND_INVALID;
      endcase
      return kind;
   endfunction

endpackage

### rtl/dsi_escape_packet_framer.sv
// A result is registered into the output stage, or into the one-entry skid stage
// when rsp stalls. Throughput: one transaction per cycle while req_stall is low;
// the state update and result are a single registered pass through dsief_step.
// Reset (synchronous, active high): API state not ready, counters and packing
// buffer cleared, output and skid stages empty.
// Depends on dsief_pkg and dsief_step.
module dsi_escape_packet_framer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dsief_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dsief_pkg::rsp_type rsp_data
);

   dsief_pkg::state_type state_ff;
   dsief_pkg::state_type state_in;
   dsief_pkg::rsp_type   result;
   dsief_pkg::rsp_type   out_ff;
   dsief_pkg::rsp_type   skid_ff;
   logic                 out_valid_ff;
   logic                 skid_valid_ff;
   logic                 accept;
   logic                 take;

   dsief_step u_step (
      .cur_state  (state_ff),
      .req_item   (req_data),
      .next_state (state_in),
      .result     (result)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (take) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= accept;
               out_ff       <= result;
            end
         end else if (out_valid_ff) begin
            if (accept) begin
               skid_ff       <= result;
               skid_valid_ff <= 1'b1;
            end
         end else begin
            out_valid_ff <= accept;
            out_ff       <= result;
         end
      end
   end

endmodule

### rtl/dsief_step.sv
// Next-state and result logic for one framer transaction.
// Depends on dsief_pkg.
module dsief_step (
   input  dsief_pkg::state_type cur_state,
   input  dsief_pkg::req_type   req_item,
   output dsief_pkg::state_type next_state,
   output dsief_pkg::rsp_type   result
);

   dsief_pkg::kind_type kind;
   logic [31:0]         acc;
   logic [15:0]         left_dec;

   assign kind     = dsief_pkg::classify(req_item.data_id);
   assign left_dec = cur_state.bytes_left - 16'd1;

   always_comb begin
      acc = {8'd0, cur_state.pack_buffer};
      case (cur_state.byte_lane)
         2'd0:    acc[7:0]   = req_item.payload_byte;
         2'd1:    acc[15:8]  = req_item.payload_byte;
         2'd2:    acc[23:16] = req_item.payload_byte;
         default: acc[31:24] = req_item.payload_byte;
      endcase
   end

   always_comb begin
      next_state           = cur_state;
      result.status        = dsief_pkg::STATUS_OK;
      result.word_valid    = 1'b0;
      result.tx_word       = 32'd0;
      result.long_frame    = 1'b0;
      result.packet_done   = 1'b0;

      case (req_item.cmd)
         dsief_pkg::CMD_HEADER: begin
            if (cur_state.api_state != dsief_pkg::ST_READY) begin
               result.status = dsief_pkg::STATUS_STATE;
            end else if (kind == dsief_pkg::KIND_INVALID) begin
               result.status = dsief_pkg::STATUS_TYPE;
            end else if (req_item.hs_mode) begin
               result.packet_done = 1'b1;
            end else if (kind == dsief_pkg::KIND_SHORT) begin
               result.word_valid  = 1'b1;
               result.tx_word     = {8'd0, req_item.param1, req_item.param0,
                                     req_item.data_id};
               result.packet_done = 1'b1;
            end else begin
               result.word_valid     = 1'b1;
               result.long_frame     = 1'b1;
               result.tx_word        = {8'd0, req_item.word_count[15:8],
                                        req_item.word_count[7:0], req_item.data_id};
               next_state.byte_lane   = 2'd0;
               next_state.pack_buffer = 24'd0;
               if (req_item.word_count == 16'd0) begin
                  result.packet_done = 1'b1;
               end else begin
                  next_state.bytes_left = req_item.word_count;
                  next_state.api_state  = dsief_pkg::ST_SENDING;
               end
            end
         end
         dsief_pkg::CMD_PAYLOAD: begin
            if (cur_state.api_state != dsief_pkg::ST_SENDING) begin
               result.status = dsief_pkg::STATUS_STATE;
            end else begin
               result.long_frame     = 1'b1;
               next_state.bytes_left = left_dec;
               if (cur_state.byte_lane == dsief_pkg::LANE_LAST || left_dec == 16'd0) begin
                  result.word_valid      = 1'b1;
                  result.tx_word         = acc;
                  next_state.pack_buffer = 24'd0;
                  next_state.byte_lane   = 2'd0;
                  if (left_dec == 16'd0) begin
                     result.packet_done   = 1'b1;
                     next_state.api_state = dsief_pkg::ST_READY;
                  end
               end else begin
                  next_state.pack_buffer = acc[23:0];
                  next_state.byte_lane   = cur_state.byte_lane + 2'd1;
               end
            end
         end
         dsief_pkg::CMD_OPEN: begin
            if (cur_state.api_state == dsief_pkg::ST_NOT_READY) begin
               next_state.api_state = dsief_pkg::ST_READY;
            end else begin
               result.status = dsief_pkg::STATUS_STATE;
            end
         end
         dsief_pkg::CMD_CLOSE: begin
            if (cur_state.api_state == dsief_pkg::ST_READY) begin
               next_state.api_state = dsief_pkg::ST_NOT_READY;
            end else begin
               result.status = dsief_pkg::STATUS_STATE;
            end
         end
         dsief_pkg::CMD_VIDEO_ON: begin
            if (cur_state.api_state == dsief_pkg::ST_READY) begin
               next_state.api_state = dsief_pkg::ST_VIDEO;
            end else begin
               result.status = dsief_pkg::STATUS_STATE;
            end
         end
         dsief_pkg::CMD_VIDEO_OFF: begin
            if (cur_state.api_state == dsief_pkg::ST_VIDEO) begin
               next_state.api_state = dsief_pkg::ST_READY;
            end else begin
               result.status = dsief_pkg::STATUS_STATE;
            end
         end
         default: begin
            result.status = dsief_pkg::STATUS_STATE;
         end
      endcase

      result.api_state_out = next_state.api_state;
   end

endmodule

### rtl/dsief_checker.sv
// Port-level checks for the DSI escape packet framer, bound to the top level.
// Depends on dsief_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dsief_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input dsief_pkg::rsp_type rsp_data
);

   logic rsp_held;
   logic rsp_error;
   logic rsp_idle_word;
   logic rsp_open_long;
   logic rsp_sending;

   assign rsp_held      = rsp_valid && rsp_stall;
   assign rsp_error     = rsp_valid && (rsp_data.status != dsief_pkg::STATUS_OK);
   assign rsp_idle_word = rsp_valid && !rsp_data.word_valid;
   assign rsp_open_long = rsp_valid && rsp_data.long_frame && !rsp_data.packet_done;
   assign rsp_sending   = rsp_data.api_state_out == dsief_pkg::ST_SENDING;

   `DSIEF_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid && !req_stall)
   `DSIEF_ASSERT(a_rsp_hold, clock, reset, rsp_held |=> rsp_valid && $stable(rsp_data))
   `DSIEF_ASSERT(a_err_no_word, clock, reset, rsp_error |-> !rsp_data.word_valid)
   `DSIEF_ASSERT(a_idle_word_zero, clock, reset, rsp_idle_word |-> rsp_data.tx_word == 32'd0)
   `DSIEF_ASSERT(a_long_state, clock, reset, rsp_open_long |-> rsp_sending)

endmodule

bind dsi_escape_packet_framer dsief_checker u_dsief_checker (.*);
